// ===== design/isc_pkg.sv =====
package isc_pkg;

  localparam int MAX_PLANES_DEF = 32;
  localparam int MAX_DIM_DEF    = 16;
  localparam int COORD_BITS_DEF = 24;

  localparam int IN_COORD_W = 24;
  localparam int PRODUCT_W  = 52;
  localparam int CNT_W      = 32;
  localparam int PIDX_W     = 16;
  localparam int JIDX_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int SIZE_W     = 7;   // holds any effective plane count or length
  localparam int Q_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NEG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_POS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd5;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PT    = 2'd1;
  localparam logic [1:0] OP_PTEND = 2'd2;
  localparam logic [1:0] OP_FIN   = 2'd3;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              allow_neg;
    logic              allow_zero;
    logic              allow_pos;
    logic              report;
    logic [SIZE_W-1:0] planes;
    logic [SIZE_W-1:0] len;
  } cfg_t;

  typedef struct packed {
    logic planes_wr;
    logic len_wr;
  } cfg_evt_t;

  typedef struct packed {
    logic                 kind;
    logic [PIDX_W-1:0]    point_index;
    logic [JIDX_W-1:0]    plane_index;
    logic [PRODUCT_W-1:0] product;
    logic                 all_ok;
    logic [CNT_W-1:0]     negative_count;
    logic [CNT_W-1:0]     zero_count;
    logic [CNT_W-1:0]     positive_count;
    logic                 last;
  } res_t;

endpackage

// ===== design/isc_queue.sv =====
module isc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = isc_pkg::Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic         rd_valid,
  output logic [W-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== design/isc_front.sv =====
module isc_front #(
  parameter int MAX_PLANES = isc_pkg::MAX_PLANES_DEF,
  parameter int MAX_DIM    = isc_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = isc_pkg::COORD_BITS_DEF,
  parameter int AW         = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [1:0]                      in_cmd,
  input  logic [isc_pkg::IN_COORD_W-1:0]  in_coord,
  input  logic                            q_full,
  output logic                            q_wr,
  output logic [2+AW+COORD_BITS-1:0]      q_data,
  input  isc_pkg::cfg_t                   cfg,
  input  isc_pkg::cfg_evt_t               cfg_evt
);

  localparam int DEPTH = MAX_PLANES * MAX_DIM;
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [AW-1:0]         load_pos_r, load_pos_nxt;
  logic [DW-1:0]         pt_pos_r, pt_pos_nxt;
  logic [1:0]            op;
  logic [AW-1:0]         addr;
  logic                  accept;
  logic signed [31:0]    cx;
  logic [COORD_BITS-1:0] coord;
  logic                  pt_done;

  assign accept  = in_push && !q_full;
  assign cx      = 32'(signed'(in_coord));
  assign coord   = cx[COORD_BITS-1:0];
  assign pt_done = (isc_pkg::SIZE_W'(pt_pos_r) + isc_pkg::SIZE_W'(1)) >= cfg.len;
  assign q_data  = {op, addr, coord};

  always_comb begin
    load_pos_nxt = load_pos_r;
    pt_pos_nxt   = pt_pos_r;
    q_wr         = 1'b0;
    op           = isc_pkg::OP_LOAD;
    addr         = load_pos_r;
    if (accept) begin
      unique case (in_cmd)
        isc_pkg::CMD_LOAD: begin
          q_wr         = 1'b1;
          load_pos_nxt = (load_pos_r == AW'(DEPTH - 1)) ? '0 : load_pos_r + AW'(1);
        end
        isc_pkg::CMD_POINT: begin
          q_wr       = 1'b1;
          addr       = AW'(pt_pos_r);
          op         = pt_done ? isc_pkg::OP_PTEND : isc_pkg::OP_PT;
          pt_pos_nxt = pt_done ? '0 : pt_pos_r + DW'(1);
        end
        isc_pkg::CMD_FINISH: begin
          q_wr = 1'b1;
          op   = isc_pkg::OP_FIN;
        end
        default: begin
        end
      endcase
    end
    // a size write restarts loading after any word taken in the same cycle
    if (cfg_evt.planes_wr || cfg_evt.len_wr) begin
      load_pos_nxt = '0;
    end
    if (cfg_evt.len_wr) begin
      pt_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      pt_pos_r   <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      pt_pos_r   <= pt_pos_nxt;
    end
  end

endmodule

// ===== design/isc_back.sv =====
module isc_back #(
  parameter int MAX_PLANES = isc_pkg::MAX_PLANES_DEF,
  parameter int MAX_DIM    = isc_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = isc_pkg::COORD_BITS_DEF,
  parameter int AW         = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [2+AW+COORD_BITS-1:0] q_data,
  output logic                       q_pop,
  input  isc_pkg::cfg_t              cfg,
  output logic                       out_v,
  output isc_pkg::res_t              out_res,
  input  logic                       out_pop
);

  localparam int DEPTH = MAX_PLANES * MAX_DIM;
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int JW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PW    = 2 * COORD_BITS;
  localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
  localparam int CB    = COORD_BITS;
  localparam int SW    = isc_pkg::SIZE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_CLS   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [CB-1:0] store_r [DEPTH];
  logic [CB-1:0] pbuf_r  [MAX_DIM];

  logic [2:0]                st_r, st_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic [DW-1:0]             k_r, k_nxt;
  logic [JW-1:0]             j_r, j_nxt;
  logic [CB-1:0]             rd_r, pb_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_sum;
  logic [isc_pkg::PIDX_W-1:0] pc_r, pc_nxt;
  logic [isc_pkg::CNT_W-1:0] neg_r, neg_nxt, zer_r, zer_nxt, pos_r, pos_nxt;
  logic                      ok_r, ok_nxt;
  logic                      hold_v_r, hold_v_nxt;
  isc_pkg::res_t             hold_r, hold_nxt;
  logic                      out_v_r, out_v_nxt;
  isc_pkg::res_t             out_r, out_nxt;

  logic [1:0]      q_op;
  logic [AW-1:0]   q_addr;
  logic [CB-1:0]   q_coord;
  logic            out_free;
  logic            is_neg, is_zero, allowed, viol_rep, stall_cls;
  logic [63:0]     acc_ext, j_ext;
  isc_pkg::res_t   rep, summ;

  assign {q_op, q_addr, q_coord} = q_data;
  assign out_free = !out_v_r || out_pop;
  assign out_v    = out_v_r;
  assign out_res  = out_r;

  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign is_neg  = acc_r[ACC_W-1];
  assign is_zero = (acc_r == '0);
  assign allowed = is_neg ? cfg.allow_neg : (is_zero ? cfg.allow_zero : cfg.allow_pos);
  assign viol_rep  = !allowed && cfg.report;
  assign stall_cls = viol_rep && hold_v_r && !out_free;
  assign acc_ext = 64'(acc_r);
  assign j_ext   = 64'(j_r);

  always_comb begin
    rep             = '0;
    rep.kind        = isc_pkg::KIND_REPORT;
    rep.point_index = pc_r;
    rep.plane_index = j_ext[isc_pkg::JIDX_W-1:0];
    rep.product     = acc_ext[isc_pkg::PRODUCT_W-1:0];
    summ                = '0;
    summ.kind           = isc_pkg::KIND_SUMMARY;
    summ.all_ok         = ok_r;
    summ.negative_count = neg_r;
    summ.zero_count     = zer_r;
    summ.positive_count = pos_r;
    summ.last           = 1'b1;
  end

  always_comb begin
    st_nxt     = st_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    acc_nxt    = acc_r;
    pc_nxt     = pc_r;
    neg_nxt    = neg_r;
    zer_nxt    = zer_r;
    pos_nxt    = pos_r;
    ok_nxt     = ok_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_pop ? 1'b0 : out_v_r;
    out_nxt    = out_r;
    q_pop      = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_op)
            isc_pkg::OP_LOAD, isc_pkg::OP_PT: begin
              q_pop = 1'b1;
            end
            isc_pkg::OP_PTEND: begin
              q_pop = 1'b1;
              if (cfg.planes == '0) begin
                pc_nxt = pc_r + isc_pkg::PIDX_W'(1);
              end else begin
                addr_nxt = '0;
                k_nxt    = '0;
                j_nxt    = '0;
                acc_nxt  = '0;
                st_nxt   = ST_RD;
              end
            end
            isc_pkg::OP_FIN: begin
              if (out_free) begin
                q_pop     = 1'b1;
                out_v_nxt = 1'b1;
                out_nxt   = summ;
                neg_nxt   = '0;
                zer_nxt   = '0;
                pos_nxt   = '0;
                pc_nxt    = '0;
                ok_nxt    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD:  st_nxt = ST_MUL;
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt  = acc_sum;
        addr_nxt = addr_r + AW'(1);
        if (SW'(k_r) + SW'(1) >= cfg.len) begin
          k_nxt  = '0;
          st_nxt = ST_CLS;
        end else begin
          k_nxt  = k_r + DW'(1);
          st_nxt = ST_RD;
        end
      end
      ST_CLS: begin
        if (!stall_cls) begin
          if (is_neg) begin
            neg_nxt = (neg_r == '1) ? neg_r : neg_r + isc_pkg::CNT_W'(1);
          end else if (is_zero) begin
            zer_nxt = (zer_r == '1) ? zer_r : zer_r + isc_pkg::CNT_W'(1);
          end else begin
            pos_nxt = (pos_r == '1) ? pos_r : pos_r + isc_pkg::CNT_W'(1);
          end
          if (!allowed) begin
            ok_nxt = 1'b0;
          end
          // a report is held back until the next one shows whether it is last
          if (viol_rep) begin
            if (hold_v_r) begin
              out_v_nxt = 1'b1;
              out_nxt   = hold_r;
            end
            hold_v_nxt = 1'b1;
            hold_nxt   = rep;
          end
          acc_nxt = '0;
          if (SW'(j_r) + SW'(1) >= cfg.planes) begin
            st_nxt = ST_FLUSH;
          end else begin
            j_nxt  = j_r + JW'(1);
            st_nxt = ST_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          pc_nxt = pc_r + isc_pkg::PIDX_W'(1);
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          hold_v_nxt   = 1'b0;
          pc_nxt       = pc_r + isc_pkg::PIDX_W'(1);
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      pc_r     <= '0;
      neg_r    <= '0;
      zer_r    <= '0;
      pos_r    <= '0;
      ok_r     <= 1'b1;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pc_r     <= pc_nxt;
      neg_r    <= neg_nxt;
      zer_r    <= zer_nxt;
      pos_r    <= pos_nxt;
      ok_r     <= ok_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    acc_r  <= acc_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    prod_r <= signed'(rd_r) * signed'(pb_r);
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop && q_op == isc_pkg::OP_LOAD) begin
      store_r[q_addr] <= q_coord;
    end
    rd_r <= store_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop && (q_op == isc_pkg::OP_PT || q_op == isc_pkg::OP_PTEND)) begin
      pbuf_r[q_addr[DW-1:0]] <= q_coord;
    end
    pb_r <= pbuf_r[k_r];
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !hold_v_r)
    else $error("held report left over in idle");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE && q_valid))
    else $error("queue popped while busy or empty");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_pop) |=> (out_v_r && $stable(out_r)))
    else $error("waiting result overwritten");

endmodule

// ===== design/incidence_sign_checker_core.sv =====
// A finish is written to the queue on acceptance and, once the back end is idle and the
// output free, popped with its summary registered at the output. A point steps through
// store read, multiply and add per coordinate and a class step per plane, taking no new word
// until idle again; other words are taken one per cycle while idle. A report waits for the
// next violation or the end of its point. A 4-word queue parts input from execution.
// Reset (rst_n low, synchronous) clears control and counters, sets ok, restores config.
module incidence_sign_checker_core #(
  parameter int MAX_PLANES = isc_pkg::MAX_PLANES_DEF,
  parameter int MAX_DIM    = isc_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = isc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_cmd,
  input  logic signed [isc_pkg::IN_COORD_W-1:0] in_coord,
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_kind,
  output logic [isc_pkg::PIDX_W-1:0]        out_point_index,
  output logic [isc_pkg::JIDX_W-1:0]        out_plane_index,
  output logic signed [isc_pkg::PRODUCT_W-1:0] out_product,
  output logic                              out_all_ok,
  output logic [isc_pkg::CNT_W-1:0]         out_negative_count,
  output logic [isc_pkg::CNT_W-1:0]         out_zero_count,
  output logic [isc_pkg::CNT_W-1:0]         out_positive_count,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_PLANES * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = 2 + AW + COORD_BITS;
  localparam int SW    = isc_pkg::SIZE_W;

  logic        an_r, az_r, ap_r, rep_r;
  logic [5:0]  planes_r;
  logic [4:0]  vlen_r;
  logic        cfg_wr;
  isc_pkg::cfg_t     cfg;
  isc_pkg::cfg_evt_t evt;

  logic          q_wr, q_full, q_valid, q_pop, out_v;
  logic [QW-1:0] q_wdata, q_rdata;
  isc_pkg::res_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign evt.planes_wr = cfg_wr && (cfg_index == isc_pkg::CFG_PLANES);
  assign evt.len_wr    = cfg_wr && (cfg_index == isc_pkg::CFG_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r     <= 1'b0;
      az_r     <= 1'b1;
      ap_r     <= 1'b0;
      rep_r    <= 1'b0;
      planes_r <= '0;
      vlen_r   <= 5'd1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        isc_pkg::CFG_ALLOW_NEG:  an_r     <= cfg_data[0];
        isc_pkg::CFG_ALLOW_ZERO: az_r     <= cfg_data[0];
        isc_pkg::CFG_ALLOW_POS:  ap_r     <= cfg_data[0];
        isc_pkg::CFG_REPORT:     rep_r    <= cfg_data[0];
        isc_pkg::CFG_PLANES:     planes_r <= cfg_data[5:0];
        isc_pkg::CFG_LENGTH:     vlen_r   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // effective sizes: length 0 acts as 1, both clamp at their maximum
  always_comb begin
    cfg.allow_neg  = an_r;
    cfg.allow_zero = az_r;
    cfg.allow_pos  = ap_r;
    cfg.report     = rep_r;
    cfg.planes     = (SW'(planes_r) > SW'(MAX_PLANES)) ? SW'(MAX_PLANES) : SW'(planes_r);
    if (vlen_r == '0) begin
      cfg.len = SW'(1);
    end else if (SW'(vlen_r) > SW'(MAX_DIM)) begin
      cfg.len = SW'(MAX_DIM);
    end else begin
      cfg.len = SW'(vlen_r);
    end
  end

  isc_front #(
    .MAX_PLANES(MAX_PLANES), .MAX_DIM(MAX_DIM), .COORD_BITS(COORD_BITS), .AW(AW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(push), .in_cmd(in_cmd), .in_coord(in_coord),
    .q_full(q_full), .q_wr(q_wr), .q_data(q_wdata),
    .cfg(cfg), .cfg_evt(evt)
  );

  isc_queue #(.W(QW), .DEPTH(isc_pkg::Q_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_data(q_rdata)
  );

  isc_back #(
    .MAX_PLANES(MAX_PLANES), .MAX_DIM(MAX_DIM), .COORD_BITS(COORD_BITS), .AW(AW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
    .cfg(cfg), .out_v(out_v), .out_res(res), .out_pop(pop && out_v)
  );

  assign full               = q_full;
  assign empty              = !out_v;
  assign out_kind           = res.kind;
  assign out_point_index    = res.point_index;
  assign out_plane_index    = res.plane_index;
  assign out_product        = res.product;
  assign out_all_ok         = res.all_ok;
  assign out_negative_count = res.negative_count;
  assign out_zero_count     = res.zero_count;
  assign out_positive_count = res.positive_count;
  assign out_last           = res.last;

endmodule
